// ===== sv/gle_pkg.sv =====
// ----------------------------------------------------------------------------
// gle_pkg: shared types and constants for the GIF LZW encoder
// Widths, state encoding, hash function, output beat type.
// ----------------------------------------------------------------------------
`default_nettype none
package gle_pkg;
    localparam int MAX_CODE_BITS = 12;
    localparam int HASH_DEPTH    = 8192;
    localparam int HASH_BITS     = $clog2(HASH_DEPTH);
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int FREE_W        = MAX_CODE_BITS + 1;
    localparam int CW_W          = 5;
    localparam int ACC_W         = 64;
    localparam int CNT_W         = 7;
    localparam int MAX_RESULTS   = 6;
    localparam int RES_W         = 3;
    // entry: code, symbol, prefix
    localparam int ENTRY_W       = CODE_W + 8 + CODE_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_LAST_PRE,
        ST_LAST_END,
        ST_FLUSH,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_frame;
    } t_out_beat;

    function automatic logic [HASH_BITS-1:0] hash_of(input logic [CODE_W-1:0] pre,
                                                     input logic [7:0] sym);
        logic [31:0] key;
        logic [31:0] prod;
        begin
            key  = (32'(pre) << 8) | 32'(sym);
            prod = key * 32'd2654435761;
            hash_of = HASH_BITS'(prod >> 7);
        end
    endfunction
endpackage
`default_nettype wire

// ===== sv/gle_if.sv =====
// ----------------------------------------------------------------------------
// gle_in_if / gle_out_if: valid/ready channels of the encoder
// Pixel beat in, packed byte beat out.
// ----------------------------------------------------------------------------
`default_nettype none
interface gle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] index_value;
    logic       last_in_frame;
    modport source (output valid, index_value, last_in_frame, input ready);
    modport sink   (input valid, index_value, last_in_frame, output ready);
endinterface

interface gle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_frame;
    modport source (output valid, out_byte, end_of_run, end_of_frame, input ready);
    modport sink   (input valid, out_byte, end_of_run, end_of_frame, output ready);
endinterface
`default_nettype wire

// ===== sv/gle_dict_ram.sv =====
// ----------------------------------------------------------------------------
// gle_dict_ram: dictionary store, one write and one registered read port
// Holds the pair entries; valid bits live with the control as an epoch mark.
// ----------------------------------------------------------------------------
`default_nettype none
module gle_dict_ram (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [gle_pkg::HASH_BITS-1:0]  i_waddr,
    input  wire logic [gle_pkg::ENTRY_W:0]      i_wdata,
    input  wire logic [gle_pkg::HASH_BITS-1:0]  i_raddr,
    output logic      [gle_pkg::ENTRY_W:0]      o_rdata
);
    import gle_pkg::*;
    logic [ENTRY_W:0] mem [HASH_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/gle_out_fifo.sv =====
// ----------------------------------------------------------------------------
// gle_out_fifo: small byte queue between the packer and the output channel
// Eight deep; the packer only starts an item with room for six beats.
// ----------------------------------------------------------------------------
`default_nettype none
module gle_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire gle_pkg::t_out_beat i_beat,
    output logic [3:0]              o_count,
    gle_out_if.source               out_ch
);
    import gle_pkg::*;
    t_out_beat  r_q [8];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_cnt;
    logic       pop;

    assign pop           = out_ch.valid && out_ch.ready;
    assign out_ch.valid  = (r_cnt != 4'd0);
    assign out_ch.out_byte     = r_q[r_rp].out_byte;
    assign out_ch.end_of_run   = r_q[r_rp].end_of_run;
    assign out_ch.end_of_frame = r_q[r_rp].end_of_frame;
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_beat;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 3'd1;
            if (pop)    r_rp <= r_rp + 3'd1;
            r_cnt <= r_cnt + 4'(i_push) - 4'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== sv/gif_lzw_encoder.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_encoder: GIF LZW compressor with LSB-first byte packing
// Hashed dictionary in one RAM, per-entry epoch marks in a second RAM.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   index_value[7:0], last_in_frame
// out_ch    out  out_byte[7:0], end_of_run, end_of_frame
// cfg       in   i_cfg_we, i_cfg_data[3:0] (min_code_size)
//
// An in-frame pixel passes through probe and check, again per extra linear
// probe, and then drains its packed bytes; the first pixel of a frame goes
// straight to the drain, and a last pixel adds states for final code, end code
// and flush. After reset the epoch RAM is swept once, before the first pixel;
// each frame start bumps the epoch, and on epoch wrap the sweep runs again.
// Input is ready only when idle with room for six more beats in the output queue.
// ----------------------------------------------------------------------------
`default_nettype none
module gif_lzw_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_data,
    gle_in_if.sink          in_ch,
    gle_out_if.source       out_ch
);
    import gle_pkg::*;

    t_state r_state, n_state;
    logic [3:0]           r_mcs;
    logic [3:0]           r_fs, n_fs;
    logic [CODE_W-1:0]    r_prefix, n_prefix;
    logic [7:0]           r_sym, n_sym;
    logic [FREE_W-1:0]    r_free, n_free;
    logic [CW_W-1:0]      r_cw, n_cw;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_in_frame, n_in_frame;
    logic                 r_last, n_last;
    logic [HASH_BITS-1:0] r_addr, n_addr;
    logic [HASH_BITS:0]   r_probes, n_probes;
    logic [HASH_BITS:0]   r_sweep, n_sweep;
    logic [7:0]           r_epoch, n_epoch;
    logic [RES_W-1:0]     r_nout, n_nout;

    logic [ENTRY_W:0] rd;
    logic [7:0]       ep_rd;
    logic [7:0]       ep_mem [HASH_DEPTH];
    logic             we, ep_we;
    logic [HASH_BITS-1:0] waddr, ep_waddr, raddr;
    logic [ENTRY_W:0] wdata;
    logic [7:0]       ep_wdata;
    logic             push;
    t_out_beat        beat;
    logic [3:0]       q_cnt;
    logic             acc_in, room;
    logic [7:0]       sym_in;
    logic [CODE_W-1:0] ecode;
    logic [ACC_W-1:0] putv;
    logic             hit_valid, hit_match;

    gle_dict_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd)
    );

    always_ff @(posedge i_clk) begin
        if (ep_we) ep_mem[ep_waddr] <= ep_wdata;
        ep_rd <= ep_mem[raddr];
    end

    gle_out_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_beat (beat),
        .o_count(q_cnt),
        .out_ch (out_ch)
    );

    assign room   = (q_cnt <= 4'd2) && (r_cnt < CNT_W'(8));
    assign in_ch.ready = (r_state == ST_IDLE) && room;
    assign acc_in = in_ch.valid && in_ch.ready;
    assign sym_in = in_ch.index_value & 8'((9'd1 << r_fs) - 9'd1);
    assign hit_valid = (ep_rd == r_epoch);
    assign hit_match = (rd[CODE_W-1:0] == r_prefix) && (rd[CODE_W+7:CODE_W] == r_sym);
    assign ecode = CODE_W'((13'd1 << r_fs) + 13'd1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            // a frame start that wrapped the epoch resumes its pixel after the sweep
            ST_CLEAR:    if (r_sweep == (HASH_BITS+1)'(HASH_DEPTH - 1)) begin
                             if (!r_in_frame) n_state = ST_IDLE;
                             else if (r_last) n_state = ST_LAST_PRE;
                             else n_state = ST_DRAIN;
                         end
            ST_IDLE:     if (acc_in && !r_in_frame && r_epoch == 8'hFF) n_state = ST_CLEAR;
                         else if (acc_in && r_in_frame) n_state = ST_PROBE;
                         else if (acc_in && in_ch.last_in_frame) n_state = ST_LAST_PRE;
                         else if (acc_in) n_state = ST_DRAIN;
            ST_PROBE:    n_state = ST_CHECK;
            ST_CHECK:    if (hit_valid && !hit_match &&
                             r_probes != (HASH_BITS+1)'(HASH_DEPTH - 1)) n_state = ST_PROBE;
                         else if (r_last) n_state = ST_LAST_PRE;
                         else n_state = ST_DRAIN;
            ST_LAST_PRE: n_state = ST_LAST_END;
            ST_LAST_END: n_state = ST_FLUSH;
            ST_FLUSH:    n_state = ST_DRAIN;
            ST_DRAIN:    if (r_cnt < CNT_W'(8)) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_fs = r_fs; n_prefix = r_prefix; n_sym = r_sym; n_free = r_free;
        n_cw = r_cw; n_acc = r_acc; n_cnt = r_cnt; n_in_frame = r_in_frame;
        n_last = r_last; n_addr = r_addr; n_probes = r_probes; n_sweep = r_sweep;
        n_epoch = r_epoch; n_nout = r_nout;
        we = 1'b0; waddr = r_addr; wdata = '0;
        ep_we = 1'b0; ep_waddr = r_addr; ep_wdata = r_epoch;
        raddr = r_addr; push = 1'b0; beat = '0;
        putv = '0;
        case (r_state)
            ST_CLEAR: begin
                ep_we = 1'b1;
                ep_waddr = r_sweep[HASH_BITS-1:0];
                ep_wdata = 8'h00;
                n_sweep = r_sweep + 1'b1;
                n_epoch = 8'h01;
            end
            ST_IDLE: begin
                n_nout = '0;
                if (acc_in) begin
                    n_last = in_ch.last_in_frame;
                    if (!r_in_frame) begin
                        if (r_mcs < 4'd2) n_fs = 4'd2;
                        else if (r_mcs > 4'd8) n_fs = 4'd8;
                        else n_fs = r_mcs;
                        n_free = FREE_W'((14'd1 << n_fs) + 14'd2);
                        n_cw = CW_W'(n_fs) + CW_W'(1);
                        n_acc = ACC_W'(14'd1 << n_fs);
                        n_cnt = CNT_W'(n_cw);
                        n_prefix = CODE_W'(in_ch.index_value &
                                           8'((9'd1 << n_fs) - 9'd1));
                        n_in_frame = 1'b1;
                        n_sweep = '0;
                        n_epoch = (r_epoch == 8'hFF) ? 8'h00 : r_epoch + 8'd1;
                    end else begin
                        n_sym = sym_in;
                        n_addr = hash_of(r_prefix, sym_in);
                        n_probes = '0;
                    end
                end
            end
            ST_PROBE: begin
                raddr = r_addr;
            end
            ST_CHECK: begin
                if (hit_valid && hit_match) begin
                    n_prefix = rd[ENTRY_W-1:CODE_W+8];
                end else if (hit_valid &&
                             r_probes != (HASH_BITS+1)'(HASH_DEPTH - 1)) begin
                    n_addr = r_addr + 1'b1;
                    n_probes = r_probes + 1'b1;
                end else begin
                    putv = ACC_W'(r_prefix) & ((ACC_W'(1) << r_cw) - ACC_W'(1));
                    n_acc = r_acc | (putv << r_cnt);
                    n_cnt = r_cnt + CNT_W'(r_cw);
                    if (r_free < FREE_W'(1 << MAX_CODE_BITS)) begin
                        if (!hit_valid) begin
                            we = 1'b1;
                            wdata = {1'b0, r_free[CODE_W-1:0], r_sym, r_prefix};
                            ep_we = 1'b1;
                        end
                        n_free = r_free + 1'b1;
                        if ((n_free > (FREE_W'(1) << r_cw)) &&
                            (r_cw < CW_W'(MAX_CODE_BITS))) n_cw = r_cw + 1'b1;
                    end
                    n_prefix = CODE_W'(r_sym);
                end
            end
            ST_LAST_PRE: begin
                putv = ACC_W'(r_prefix) & ((ACC_W'(1) << r_cw) - ACC_W'(1));
                n_acc = r_acc | (putv << r_cnt);
                n_cnt = r_cnt + CNT_W'(r_cw);
                if ((r_free >= (FREE_W'(1) << r_cw)) &&
                    (r_cw < CW_W'(MAX_CODE_BITS))) n_cw = r_cw + 1'b1;
            end
            ST_LAST_END: begin
                putv = ACC_W'(ecode) & ((ACC_W'(1) << r_cw) - ACC_W'(1));
                n_acc = r_acc | (putv << r_cnt);
                n_cnt = r_cnt + CNT_W'(r_cw);
            end
            ST_FLUSH: begin
                if (r_cnt[2:0] != 3'd0) n_cnt = {r_cnt[CNT_W-1:3] + 1'b1, 3'd0};
                n_in_frame = 1'b0;
            end
            ST_DRAIN: begin
                if (r_cnt >= CNT_W'(8)) begin
                    push = (r_nout < RES_W'(MAX_RESULTS));
                    n_nout = r_nout + RES_W'(push);
                    beat.out_byte = r_acc[7:0];
                    beat.end_of_run = (r_cnt < CNT_W'(16)) ||
                                      (r_nout == RES_W'(MAX_RESULTS - 1));
                    beat.end_of_frame = beat.end_of_run && r_last;
                    n_acc = r_acc >> 8;
                    n_cnt = r_cnt - CNT_W'(8);
                end
                if (r_last && n_cnt < CNT_W'(8)) begin
                    n_acc = '0;
                    n_cnt = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym; r_addr <= n_addr;
        r_probes <= n_probes;
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_mcs <= 4'd8; r_fs <= 4'd8;
            r_prefix <= '0;
            r_free <= FREE_W'(258); r_cw <= CW_W'(9);
            r_acc <= '0; r_cnt <= '0;
            r_in_frame <= 1'b0; r_last <= 1'b0;
            r_sweep <= '0; r_epoch <= 8'h01; r_nout <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mcs <= i_cfg_data;
            r_prefix <= n_prefix; r_acc <= n_acc;
            r_fs <= n_fs; r_free <= n_free; r_cw <= n_cw; r_cnt <= n_cnt;
            r_in_frame <= n_in_frame; r_last <= n_last;
            r_sweep <= n_sweep; r_epoch <= n_epoch; r_nout <= n_nout;
        end
    end
endmodule
`default_nettype wire
